/* design/cnv3_pkg.sv */
// ----------------------------------------------------------------------------
// cnv3_pkg: shared types and helpers for the 3x3 same-padding convolution
// Opcodes, controller states, the MAC control word and the Q16.16 to Q8.8
// rounding with saturation.
// ----------------------------------------------------------------------------
package cnv3_pkg;

   // accumulator width: 64 chans * 9 taps * 2^30 fits well inside 48 bits
   localparam int ACC_W = 48;

   typedef enum logic [1:0] {
      OP_WR_PIXEL  = 2'd0,
      OP_WR_WEIGHT = 2'd1,
      OP_COMPUTE   = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;   // zero the accumulator
      logic vld;     // operand pair present and tap inside the image
   } mac_ctrl_type;

   // Q16.16 sum to Q8.8, round half to even, saturate to 16 bits
   function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] sum);
      logic signed [ACC_W-8:0] q;
      logic [7:0]              frac;
      logic                    up;
      q    = {sum[ACC_W-1], sum[ACC_W-1:8]};
      frac = sum[7:0];
      up   = (frac > 8'd128) || ((frac == 8'd128) && q[0]);
      q    = q + $signed({{(ACC_W-8){1'b0}}, up});
      if (q > (ACC_W-7)'(32767)) begin
         q = (ACC_W-7)'(32767);
      end else if (q < -(ACC_W-7)'(32768)) begin
         q = -(ACC_W-7)'(32768);
      end
      return q[15:0];
   endfunction

endpackage

/* design/cnv3_mac.sv */
// ----------------------------------------------------------------------------
// cnv3_mac: multiply-accumulate stage
// Registered 16x16 signed product, then exact accumulation into ACC_W bits.
// ----------------------------------------------------------------------------
module cnv3_mac (
   input  logic                               clock,
   input  logic                               reset,
   input  cnv3_pkg::mac_ctrl_type             ctrl,
   input  logic signed [15:0]                 pix,
   input  logic signed [15:0]                 wgt,
   output logic signed [cnv3_pkg::ACC_W-1:0]  acc
);
   import cnv3_pkg::*;

   logic signed [31:0]      prod_ff;
   logic signed [31:0]      prod_in;
   logic                    pvld_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;

   assign prod_in = pix * wgt;

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (pvld_ff) begin
         acc_in = acc_ff + {{(ACC_W-32){prod_ff[31]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (reset) begin
         pvld_ff <= 1'b0;
      end else begin
         pvld_ff <= ctrl.vld;
      end
   end

   assign acc = acc_ff;

endmodule

/* design/conv3x3_same_pad_q88_top.sv */
// ----------------------------------------------------------------------------
// conv3x3_same_pad_q88_top: 3x3 same-padding convolution on Q8.8 data
// Pixel and weight words fill two on-chip memories; a compute word walks all
// input channels and nine taps through one MAC and returns one Q8.8 pixel.
// ----------------------------------------------------------------------------
//
//   channel | ports                          | direction | moves
//   --------+--------------------------------+-----------+---------------------
//   req     | req_valid, req_stall, req_*    | in        | write or compute word
//   rsp     | rsp_valid, rsp_stall, rsp_*    | out       | one output pixel
//
// A write word goes straight into its memory.
// A compute word does one memory read pair per tap, set by the single read
// port of each memory; the read, the multiply and the accumulate are each
// registered, and the result is then loaded into the output register.
// Reset (synchronous, active high) clears control only; memory contents stay
// undefined until written. req_stall is high while a compute runs; a held
// result in the output register does not block new words, but a finished
// compute waits in ST_FINISH until that register is free.
//
module conv3x3_same_pad_q88_top #(
   parameter int IN_CHANS   = 4,
   parameter int OUT_CHANS  = 4,
   parameter int IMG_HEIGHT = 16,
   parameter int IMG_WIDTH  = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic [1:0]         req_in_chan,
   input  logic [1:0]         req_out_chan,
   input  logic [3:0]         req_pix_row,
   input  logic [3:0]         req_pix_col,
   input  logic [1:0]         req_tap_row,
   input  logic [1:0]         req_tap_col,
   input  logic signed [15:0] req_data_value,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_result_value,
   output logic [1:0]         rsp_res_chan,
   output logic [3:0]         rsp_res_row,
   output logic [3:0]         rsp_res_col
);
   import cnv3_pkg::*;

   localparam int FEAT_DEPTH = IN_CHANS * IMG_HEIGHT * IMG_WIDTH;
   localparam int WGT_DEPTH  = OUT_CHANS * IN_CHANS * 9;
   localparam int FA_W       = $clog2(FEAT_DEPTH);
   localparam int WA_W       = $clog2(WGT_DEPTH);
   localparam int CW         = (IN_CHANS > 1) ? $clog2(IN_CHANS) : 1;

   // memories
   logic [15:0] feat_mem [FEAT_DEPTH];
   logic [15:0] wgt_mem  [WGT_DEPTH];

   // handshake / decode
   logic        req_acc;
   logic        feat_we;
   logic        wgt_we;
   logic        cmp_go;
   logic [31:0] feat_widx;
   logic [31:0] wgt_widx;

   // controller
   state_type   state_ff, state_in;
   logic [CW-1:0] c_ff, c_in;
   logic [1:0]  kr_ff, kr_in;
   logic [1:0]  kc_ff, kc_in;
   logic        drain_ff, drain_in;
   logic [1:0]  oc_ff;
   logic [3:0]  row_ff;
   logic [3:0]  col_ff;
   logic        last_tap;

   // read side
   logic [5:0]  tr;
   logic [5:0]  tc;
   logic        tap_in;
   logic [31:0] feat_ridx;
   logic [31:0] wgt_ridx;
   logic [15:0] feat_rd_ff;
   logic [15:0] wgt_rd_ff;
   logic        s1_vld_ff, s1_vld_in;

   // MAC
   mac_ctrl_type            mac_ctrl;
   logic signed [ACC_W-1:0] acc;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_value_ff;
   logic [1:0]         rsp_chan_ff;
   logic [3:0]         rsp_row_ff;
   logic [3:0]         rsp_col_ff;
   logic               rsp_load;

   // ------------------------------------------------------------------
   // request decode
   // ------------------------------------------------------------------
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;

   always_comb begin
      feat_we = 1'b0;
      wgt_we  = 1'b0;
      cmp_go  = 1'b0;
      if (req_acc) begin
         unique case (opcode_type'(req_opcode))
            OP_WR_PIXEL: begin
               feat_we = (32'(req_in_chan) < IN_CHANS) && (32'(req_pix_row) < IMG_HEIGHT)
                         && (32'(req_pix_col) < IMG_WIDTH);
            end
            OP_WR_WEIGHT: begin
               wgt_we = (32'(req_out_chan) < OUT_CHANS) && (32'(req_in_chan) < IN_CHANS)
                        && (req_tap_row != 2'd3) && (req_tap_col != 2'd3);
            end
            OP_COMPUTE: begin
               cmp_go = (32'(req_out_chan) < OUT_CHANS) && (32'(req_pix_row) < IMG_HEIGHT)
                        && (32'(req_pix_col) < IMG_WIDTH);
            end
            default: begin
               // unused opcode: dropped
            end
         endcase
      end
   end

   assign feat_widx = (32'(req_in_chan) * IMG_HEIGHT + 32'(req_pix_row)) * IMG_WIDTH
                      + 32'(req_pix_col);
   assign wgt_widx  = (32'(req_out_chan) * IN_CHANS + 32'(req_in_chan)) * 9
                      + 32'(req_tap_row) * 3 + 32'(req_tap_col);

   // ------------------------------------------------------------------
   // tap walk: channel outer, kernel row, kernel column inner
   // ------------------------------------------------------------------
   assign last_tap = (c_ff == CW'(IN_CHANS - 1)) && (kr_ff == 2'd2) && (kc_ff == 2'd2);

   // tr/tc are image row/col plus one; zero or past the edge means padding
   assign tr     = 6'(row_ff) + 6'(kr_ff);
   assign tc     = 6'(col_ff) + 6'(kc_ff);
   assign tap_in = (tr != 6'd0) && (32'(tr) <= IMG_HEIGHT)
                   && (tc != 6'd0) && (32'(tc) <= IMG_WIDTH);

   // padded taps may alias any entry; their product is masked
   assign feat_ridx = (32'(c_ff) * IMG_HEIGHT + 32'(tr) - 32'd1) * IMG_WIDTH
                      + 32'(tc) - 32'd1;
   assign wgt_ridx  = (32'(oc_ff) * IN_CHANS + 32'(c_ff)) * 9
                      + 32'(kr_ff) * 3 + 32'(kc_ff);

   assign s1_vld_in = (state_ff == ST_RUN) && tap_in;

   always_comb begin
      state_in = state_ff;
      c_in     = c_ff;
      kr_in    = kr_ff;
      kc_in    = kc_ff;
      drain_in = drain_ff;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmp_go) begin
               state_in = ST_RUN;
               c_in     = '0;
               kr_in    = '0;
               kc_in    = '0;
            end
         end
         ST_RUN: begin
            if (last_tap) begin
               state_in = ST_DRAIN;
               drain_in = 1'b0;
            end else if (kc_ff == 2'd2) begin
               kc_in = '0;
               if (kr_ff == 2'd2) begin
                  kr_in = '0;
                  c_in  = c_ff + CW'(1);
               end else begin
                  kr_in = kr_ff + 2'd1;
               end
            end else begin
               kc_in = kc_ff + 2'd1;
            end
         end
         ST_DRAIN: begin
            // wait for the product register, then the final accumulate
            if (drain_ff) begin
               state_in = ST_FINISH;
            end else begin
               drain_in = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         c_ff      <= '0;
         kr_ff     <= '0;
         kc_ff     <= '0;
         drain_ff  <= 1'b0;
         s1_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         c_ff      <= c_in;
         kr_ff     <= kr_in;
         kc_ff     <= kc_in;
         drain_ff  <= drain_in;
         s1_vld_ff <= s1_vld_in;
      end
   end

   // request fields held for the whole compute
   always_ff @(posedge clock) begin
      if (cmp_go) begin
         oc_ff  <= req_out_chan;
         row_ff <= req_pix_row;
         col_ff <= req_pix_col;
      end
   end

   // ------------------------------------------------------------------
   // memories: one write port, one registered read port each
   // writes happen only in ST_IDLE, only reads issued in ST_RUN are used: no overlap
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (feat_we) begin
         feat_mem[FA_W'(feat_widx)] <= req_data_value;
      end
      feat_rd_ff <= feat_mem[FA_W'(feat_ridx)];
   end

   always_ff @(posedge clock) begin
      if (wgt_we) begin
         wgt_mem[WA_W'(wgt_widx)] <= req_data_value;
      end
      wgt_rd_ff <= wgt_mem[WA_W'(wgt_ridx)];
   end

   // ------------------------------------------------------------------
   // MAC
   // ------------------------------------------------------------------
   assign mac_ctrl.clear = cmp_go;
   assign mac_ctrl.vld   = s1_vld_ff;

   cnv3_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .pix   ($signed(feat_rd_ff)),
      .wgt   ($signed(wgt_rd_ff)),
      .acc   (acc)
   );

   // ------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff <= round_sat(acc);
         rsp_chan_ff  <= oc_ff;
         rsp_row_ff   <= row_ff;
         rsp_col_ff   <= col_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_res_chan     = rsp_chan_ff;
   assign rsp_res_row      = rsp_row_ff;
   assign rsp_res_col      = rsp_col_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // operand pairs only follow a tap issued in ST_RUN
   a_s1_from_run: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |-> ($past(state_ff) == ST_RUN))
      else $error("operand pair without a tap issue");

   // pipeline is empty when the result is taken
   a_finish_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> !s1_vld_ff)
      else $error("result taken with taps in flight");

   // a new result only comes out of ST_FINISH
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) == ST_FINISH))
      else $error("result without a finished compute");

   // a compute starts from the first tap
   a_walk_start: assert property (@(posedge clock) disable iff (reset)
      cmp_go |=> ((state_ff == ST_RUN) && (c_ff == '0) && (kr_ff == 2'd0)
                  && (kc_ff == 2'd0)))
      else $error("tap walk did not start at the first tap");

endmodule
